// ===== rtl/yags_pkg.sv =====
// Shared types, constants and defaults of the YAGS branch predictor.
`default_nettype none

package yags_pkg;

	// Fixed field widths
	localparam int ADDR_W      = 32;
	localparam int HIST_OUT_W  = 10;
	localparam int CMD_W       = 3;
	localparam int SHIFT_W     = 3;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_LOOKUP   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_UNCOND   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_UPDATE   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RESTORE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_BTB_MISS = 3'd4;

	// Register file
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-3:0] REG_ADDRESS_SHIFT = 1'b0;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd2;

	// Default sizes
	localparam int CHOICE_ENTRIES_DEF      = 4096;
	localparam int CACHE_ENTRIES_DEF       = 1024;
	localparam int CHOICE_COUNTER_BITS_DEF = 2;
	localparam int CACHE_COUNTER_BITS_DEF  = 2;
	localparam int TAG_BITS_DEF            = 8;

	// Request transaction
	typedef struct packed {
		logic [CMD_W-1:0]      cmd;
		logic [ADDR_W-1:0]     branch_address;
		logic                  outcome_taken;
		logic                  was_squashed;
		logic [HIST_OUT_W-1:0] saved_history;
		logic                  saved_choice_taken;
		logic                  saved_final_prediction;
		logic                  saved_cache_hit;
	} yags_req_t;

	// Response transaction
	typedef struct packed {
		logic                  prediction;
		logic                  choice_taken;
		logic                  cache_hit;
		logic [HIST_OUT_W-1:0] history_snapshot;
	} yags_rsp_t;

	// Datapath status seen by the top level
	typedef struct packed {
		logic clearing;
		logic busy_s1;
	} yags_status_t;

endpackage

`default_nettype wire

// ===== rtl/yags_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module yags_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and read the old contents
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/yags_apb_regs.sv =====
// APB register file holding the address shift.
`default_nettype none

module yags_apb_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [yags_pkg::APB_AW-1:0]       paddr,
	input  wire logic [yags_pkg::APB_DW-1:0]       pwdata,
	output      logic [yags_pkg::APB_DW-1:0]       prdata,
	output      logic                              pready,
	output      logic [yags_pkg::SHIFT_W-1:0]      address_shift
);

	logic [yags_pkg::SHIFT_W-1:0] shift_q;
	logic                         hit_shift;

	assign hit_shift     = (paddr[yags_pkg::APB_AW-1:2] == yags_pkg::REG_ADDRESS_SHIFT);
	assign pready        = 1'b1;
	assign address_shift = shift_q;

	// Take the register write in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= yags_pkg::SHIFT_RESET;
		end else if (psel && penable && pwrite && hit_shift) begin
			shift_q <= pwdata[yags_pkg::SHIFT_W-1:0];
		end
	end

	// Return the addressed register
	always_comb begin
		prdata = '0;
		if (hit_shift) begin
			prdata = {{(yags_pkg::APB_DW-yags_pkg::SHIFT_W){1'b0}}, shift_q};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/yags_datapath.sv =====
// Predictor datapath: table clear, input stage, predict/train logic, result register.
`default_nettype none

module yags_datapath #(
	parameter int CHOICE_ENTRIES      = yags_pkg::CHOICE_ENTRIES_DEF,
	parameter int CACHE_ENTRIES       = yags_pkg::CACHE_ENTRIES_DEF,
	parameter int CHOICE_COUNTER_BITS = yags_pkg::CHOICE_COUNTER_BITS_DEF,
	parameter int CACHE_COUNTER_BITS  = yags_pkg::CACHE_COUNTER_BITS_DEF,
	parameter int TAG_BITS            = yags_pkg::TAG_BITS_DEF,
	localparam int CIB = $clog2(CHOICE_ENTRIES),
	localparam int HB  = $clog2(CACHE_ENTRIES),
	localparam int RB  = HB - 1,
	localparam int EW  = 2 * (CACHE_COUNTER_BITS + TAG_BITS),
	localparam int RW  = 2 * EW
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [yags_pkg::SHIFT_W-1:0]  address_shift,
	input  wire logic                          req_valid,
	output      logic                          req_ready,
	input  wire yags_pkg::yags_req_t           req,
	output      logic                          rsp_valid,
	input  wire logic                          rsp_ready,
	output      yags_pkg::yags_rsp_t           rsp,
	output      yags_pkg::yags_status_t        status,
	// choice table port
	output      logic                          c_we,
	output      logic [CIB-1:0]                c_waddr,
	output      logic [CHOICE_COUNTER_BITS-1:0] c_wdata,
	output      logic                          c_re,
	output      logic [CIB-1:0]                c_raddr,
	input  wire logic [CHOICE_COUNTER_BITS-1:0] c_rdata,
	// direction cache port, two entries per row
	output      logic                          k_we,
	output      logic [RB-1:0]                 k_waddr,
	output      logic [RW-1:0]                 k_wdata,
	output      logic                          k_re,
	output      logic [RB-1:0]                 k_raddr,
	input  wire logic [RW-1:0]                 k_rdata
);

	localparam int CB   = CHOICE_COUNTER_BITS;
	localparam int KB   = CACHE_COUNTER_BITS;
	localparam int HO   = yags_pkg::HIST_OUT_W;
	localparam int RD   = CACHE_ENTRIES / 2;
	localparam int MAXD = (CHOICE_ENTRIES > RD) ? CHOICE_ENTRIES : RD;
	localparam int CLW  = $clog2(MAXD + 1);

	typedef struct packed {
		logic [KB-1:0]       t_ctr;
		logic [TAG_BITS-1:0] t_tag;
		logic [KB-1:0]       n_ctr;
		logic [TAG_BITS-1:0] n_tag;
	} entry_t;

	typedef entry_t [1:0] row_t;

	function automatic logic [CB-1:0] train_c(input logic [CB-1:0] c, input logic up);
		logic [CB-1:0] r;
		r = c;
		if (up) begin
			if (c != {CB{1'b1}}) r = c + CB'(1);
		end else begin
			if (c != '0) r = c - CB'(1);
		end
		return r;
	endfunction

	function automatic logic [KB-1:0] train_k(input logic [KB-1:0] c, input logic up);
		logic [KB-1:0] r;
		r = c;
		if (up) begin
			if (c != {KB{1'b1}}) r = c + KB'(1);
		end else begin
			if (c != '0) r = c - KB'(1);
		end
		return r;
	endfunction

	// Control state
	logic [CLW-1:0] clr_q;
	logic           clearing;
	logic           valid_s1;
	logic           rsp_valid_q;
	logic [HB-1:0]  hist_q;
	logic           cfwd_hit_q;
	logic           kfwd_hit_q;

	// Payload registers
	yags_pkg::yags_req_t  item_s1;
	logic [CIB-1:0]       cidx_s1;
	logic [RB-1:0]        row_s1;
	logic                 sh0_s1;
	logic [CB-1:0]        cfwd_data_q;
	row_t                 kfwd_data_q;
	yags_pkg::yags_rsp_t  rsp_q;

	// Handshake
	logic advance;
	logic accept;

	// Accept-side index logic
	logic [yags_pkg::ADDR_W-1:0] shifted_in;
	logic [HB+HO-1:0]            saved_ext_in;
	logic [HB-1:0]               saved_in;
	logic [HB-1:0]               hist_base;
	logic [HB-1:0]               gidx_in;

	// Stage logic
	logic [CB-1:0]       choice_ctr;
	row_t                row_cur;
	row_t                row_new;
	entry_t              ent;
	entry_t              ent_new;
	logic                sel;
	logic [HB+HO-1:0]    saved_ext_s1;
	logic [HB-1:0]       saved_s1;
	logic [HB+HO-1:0]    hist_ext;
	logic [TAG_BITS-1:0] tag;
	logic                choice;
	logic                pred;
	logic                hit;
	logic                choice_train;
	logic                is_update;
	logic [HB-1:0]       hist_nx;
	yags_pkg::yags_rsp_t rsp_nx;

	assign clearing  = (clr_q != CLW'(MAXD));
	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !clearing && (!valid_s1 || advance);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign status    = '{clearing: clearing, busy_s1: valid_s1};

	// Work out the read indices of an arriving transaction
	always_comb begin
		shifted_in   = req.branch_address >> address_shift;
		saved_ext_in = {{HB{1'b0}}, req.saved_history};
		saved_in     = saved_ext_in[HB-1:0];
		// history ahead of this transaction; only its upper bits are used here
		hist_base    = valid_s1 ? hist_nx : hist_q;
		if (req.cmd == yags_pkg::CMD_UPDATE) begin
			gidx_in = shifted_in[HB-1:0] ^ saved_in;
		end else begin
			gidx_in = shifted_in[HB-1:0] ^ hist_base;
		end
	end

	assign c_re    = accept;
	assign c_raddr = shifted_in[CIB-1:0];
	assign k_re    = accept;
	assign k_raddr = gidx_in[HB-1:1];

	// Predict and train for the held transaction
	always_comb begin
		is_update    = (item_s1.cmd == yags_pkg::CMD_UPDATE);
		saved_ext_s1 = {{HB{1'b0}}, item_s1.saved_history};
		saved_s1     = saved_ext_s1[HB-1:0];
		hist_ext     = {{HO{1'b0}}, hist_q};
		tag          = item_s1.branch_address[TAG_BITS-1:0];
		choice_ctr   = cfwd_hit_q ? cfwd_data_q : c_rdata;
		row_cur      = kfwd_hit_q ? kfwd_data_q : row_t'(k_rdata);
		sel          = sh0_s1 ^ (is_update ? saved_s1[0] : hist_q[0]);
		ent          = row_cur[sel];
		choice       = choice_ctr[CB-1];

		// lookup: opposite cache overrides the choice on a tag hit
		if (choice) begin
			hit  = (ent.n_tag == tag);
			pred = hit ? ent.n_ctr[KB-1] : 1'b1;
		end else begin
			hit  = (ent.t_tag == tag);
			pred = hit ? ent.t_ctr[KB-1] : 1'b0;
		end

		// resolve: train counters, allocate on an undecided misprediction
		ent_new      = ent;
		choice_train = 1'b1;
		if (item_s1.saved_cache_hit) begin
			if (item_s1.saved_choice_taken) begin
				ent_new.n_ctr = train_k(ent.n_ctr, item_s1.outcome_taken);
			end else begin
				ent_new.t_ctr = train_k(ent.t_ctr, item_s1.outcome_taken);
			end
			choice_train = (item_s1.saved_final_prediction != item_s1.outcome_taken)
				|| (item_s1.outcome_taken == item_s1.saved_choice_taken);
		end else if (item_s1.saved_final_prediction != item_s1.outcome_taken) begin
			if (item_s1.outcome_taken) begin
				ent_new.t_tag = tag;
			end else begin
				ent_new.n_tag = tag;
			end
		end
		row_new      = row_cur;
		row_new[sel] = ent_new;

		// result and next history per command
		rsp_nx                  = '0;
		rsp_nx.history_snapshot = hist_ext[HO-1:0];
		hist_nx                 = hist_q;
		unique case (item_s1.cmd)
			yags_pkg::CMD_LOOKUP: begin
				rsp_nx.prediction   = pred;
				rsp_nx.choice_taken = choice;
				rsp_nx.cache_hit    = hit;
				hist_nx             = {hist_q[HB-2:0], pred};
			end
			yags_pkg::CMD_UNCOND: begin
				rsp_nx.prediction   = 1'b1;
				rsp_nx.choice_taken = 1'b1;
				hist_nx             = {hist_q[HB-2:0], 1'b1};
			end
			yags_pkg::CMD_UPDATE: begin
				if (item_s1.was_squashed) begin
					hist_nx = {saved_s1[HB-2:0], item_s1.outcome_taken};
				end
			end
			yags_pkg::CMD_RESTORE: begin
				hist_nx = saved_s1;
			end
			yags_pkg::CMD_BTB_MISS: begin
				hist_nx = {hist_q[HB-1:1], 1'b0};
			end
			default: begin
				hist_nx = hist_q;
			end
		endcase
	end

	// Table writes: clearing sweep, else training on the way out
	always_comb begin
		if (clearing) begin
			c_we    = 1'b1;
			c_waddr = clr_q[CIB-1:0];
			c_wdata = '0;
			k_we    = 1'b1;
			k_waddr = clr_q[RB-1:0];
			k_wdata = '0;
		end else begin
			c_we    = advance && is_update && choice_train;
			c_waddr = cidx_s1;
			c_wdata = train_c(choice_ctr, item_s1.outcome_taken);
			k_we    = advance && is_update;
			k_waddr = row_s1;
			k_wdata = RW'(row_new);
		end
	end

	// Advance control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			hist_q      <= '0;
			cfwd_hit_q  <= 1'b0;
			kfwd_hit_q  <= 1'b0;
		end else begin
			if (clearing) begin
				clr_q <= clr_q + CLW'(1);
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
				hist_q      <= hist_nx;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			// a write at the edge of the read is not seen by the read
			if (accept) begin
				cfwd_hit_q <= c_we && (c_waddr == c_raddr);
				kfwd_hit_q <= k_we && (k_waddr == k_raddr);
			end
		end
	end

	// Hold payload of the stage and the result
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= req;
			cidx_s1     <= c_raddr;
			row_s1      <= k_raddr;
			sh0_s1      <= shifted_in[0];
			cfwd_data_q <= c_wdata;
			kfwd_data_q <= row_t'(k_wdata);
		end
		if (advance) begin
			rsp_q <= rsp_nx;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/yags_branch_predictor.sv =====
// Top level of the YAGS branch predictor.
// Requests come in on req (req_valid/req_ready) and each gives exactly one
// response on rsp (rsp_valid/rsp_ready), in order. A transaction is a lookup,
// unconditional branch, resolve update, squash restore or BTB miss.
// A request goes through the input stage, then the response register.
// Throughput is one transaction per cycle while the receiver takes responses:
// the tables are single-read, single-write RAMs with registered read,
// and a resolve update writes back as it leaves the input stage.
// After reset the tables are cleared one row a cycle, sweeping max(CHOICE_ENTRIES,
// CACHE_ENTRIES/2) addresses (4096 at the default sizes); req_ready stays low
// until that is done, while APB register writes are taken throughout.
// The address shift register sits at APB address 0 and resets to 2; write it
// only while no transaction is in flight.
// When the receiver stalls, the response register holds and the input stage
// holds one more transaction; req_ready drops when both are full.
`default_nettype none

module yags_branch_predictor #(
	parameter int CHOICE_ENTRIES      = yags_pkg::CHOICE_ENTRIES_DEF,
	parameter int CACHE_ENTRIES       = yags_pkg::CACHE_ENTRIES_DEF,
	parameter int CHOICE_COUNTER_BITS = yags_pkg::CHOICE_COUNTER_BITS_DEF,
	parameter int CACHE_COUNTER_BITS  = yags_pkg::CACHE_COUNTER_BITS_DEF,
	parameter int TAG_BITS            = yags_pkg::TAG_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output      logic                        req_ready,
	input  wire yags_pkg::yags_req_t         req,
	output      logic                        rsp_valid,
	input  wire logic                        rsp_ready,
	output      yags_pkg::yags_rsp_t         rsp,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [yags_pkg::APB_AW-1:0] paddr,
	input  wire logic [yags_pkg::APB_DW-1:0] pwdata,
	output      logic [yags_pkg::APB_DW-1:0] prdata,
	output      logic                        pready
);

	localparam int CIB = $clog2(CHOICE_ENTRIES);
	localparam int HB  = $clog2(CACHE_ENTRIES);
	localparam int RB  = HB - 1;
	localparam int EW  = 2 * (CACHE_COUNTER_BITS + TAG_BITS);
	localparam int RW  = 2 * EW;

	logic [yags_pkg::SHIFT_W-1:0]   address_shift;
	yags_pkg::yags_status_t         status;
	logic                           c_we;
	logic [CIB-1:0]                 c_waddr;
	logic [CHOICE_COUNTER_BITS-1:0] c_wdata;
	logic                           c_re;
	logic [CIB-1:0]                 c_raddr;
	logic [CHOICE_COUNTER_BITS-1:0] c_rdata;
	logic                           k_we;
	logic [RB-1:0]                  k_waddr;
	logic [RW-1:0]                  k_wdata;
	logic                           k_re;
	logic [RB-1:0]                  k_raddr;
	logic [RW-1:0]                  k_rdata;

	// Configuration registers
	yags_apb_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.address_shift (address_shift)
	);

	// Choice counters
	yags_ram #(
		.WIDTH (CHOICE_COUNTER_BITS),
		.DEPTH (CHOICE_ENTRIES)
	) u_choice_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.re    (c_re),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	// Taken and not-taken caches, two entries per row
	yags_ram #(
		.WIDTH (RW),
		.DEPTH (CACHE_ENTRIES / 2)
	) u_cache_ram (
		.clk   (clk),
		.we    (k_we),
		.waddr (k_waddr),
		.wdata (k_wdata),
		.re    (k_re),
		.raddr (k_raddr),
		.rdata (k_rdata)
	);

	// Predict and train
	yags_datapath #(
		.CHOICE_ENTRIES      (CHOICE_ENTRIES),
		.CACHE_ENTRIES       (CACHE_ENTRIES),
		.CHOICE_COUNTER_BITS (CHOICE_COUNTER_BITS),
		.CACHE_COUNTER_BITS  (CACHE_COUNTER_BITS),
		.TAG_BITS            (TAG_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.address_shift (address_shift),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.rsp           (rsp),
		.status        (status),
		.c_we          (c_we),
		.c_waddr       (c_waddr),
		.c_wdata       (c_wdata),
		.c_re          (c_re),
		.c_raddr       (c_raddr),
		.c_rdata       (c_rdata),
		.k_we          (k_we),
		.k_waddr       (k_waddr),
		.k_wdata       (k_wdata),
		.k_re          (k_re),
		.k_raddr       (k_raddr),
		.k_rdata       (k_rdata)
	);

	// No request taken while the tables are being cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		status.clearing |-> !req_ready)
		else $error("request accepted during table clear");

	// Clearing runs once after reset and never restarts
	assert property (@(posedge clk) disable iff (!arst_n)
		!status.clearing |=> !status.clearing)
		else $error("table clear restarted");

	// A full input stage behind a stalled response blocks new requests
	assert property (@(posedge clk) disable iff (!arst_n)
		(status.busy_s1 && rsp_valid && !rsp_ready) |-> !req_ready)
		else $error("input stage overwritten while stalled");

	// An accepted request occupies the input stage next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> status.busy_s1)
		else $error("accepted request lost");

endmodule

`default_nettype wire

// ===== verif/tb_yags_branch_predictor.sv =====
// Self-checking testbench for the YAGS branch predictor: predicts every transaction and compares.
`default_nettype none

module tb_yags_branch_predictor;
	import yags_pkg::*;

	localparam int CHOICE_N      = CHOICE_ENTRIES_DEF;
	localparam int CACHE_N       = CACHE_ENTRIES_DEF;
	localparam int CHOICE_CW     = CHOICE_COUNTER_BITS_DEF;
	localparam int CACHE_CW      = CACHE_COUNTER_BITS_DEF;
	localparam int TAG_W         = TAG_BITS_DEF;
	localparam int CHOICE_IW     = $clog2(CHOICE_N);
	localparam int HIST_W        = $clog2(CACHE_N);
	localparam int CHOICE_MAX    = (1 << CHOICE_CW) - 1;
	localparam int CACHE_MAX     = (1 << CACHE_CW) - 1;
	localparam int CHOICE_THRESH = (1 << (CHOICE_CW - 1)) - 1;
	localparam int CACHE_THRESH  = (1 << (CACHE_CW - 1)) - 1;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [APB_AW-1:0] SHIFT_REG_ADDR = {REG_ADDRESS_SHIFT, 2'b00};

	typedef struct {
		logic [ADDR_W-1:0] pc;
		int                bias;
		yags_rsp_t         seen;
	} open_branch_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	yags_req_t         req = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	yags_rsp_t         rsp;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	// Predictor state
	logic [CHOICE_CW-1:0] choice_ctr [CHOICE_N];
	logic [CACHE_CW-1:0]  taken_ctr [CACHE_N];
	logic [CACHE_CW-1:0]  not_taken_ctr [CACHE_N];
	logic [TAG_W-1:0]     taken_tag [CACHE_N];
	logic [TAG_W-1:0]     not_taken_tag [CACHE_N];
	logic [HIST_W-1:0]    global_hist = '0;
	logic [SHIFT_W-1:0]   shift_amt = SHIFT_RESET;

	yags_rsp_t    predicted_rsp_q [$];
	open_branch_t open_branches [$];
	yags_rsp_t    expected_rsp;
	int           mismatch_count = 0;
	int           quiet_cycles = 0;
	int           rsp_hold_left = 0;
	bit           idle_en = 1'b1;

	yags_branch_predictor u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	// Step a saturating counter one place up or down
	function automatic int unsigned sat_step(input int unsigned cur, input logic up,
			input int unsigned top);
		if (up) begin
			return (cur < top) ? cur + 1 : cur;
		end
		return (cur > 0) ? cur - 1 : cur;
	endfunction

	// Work out the response of one transaction and advance the predictor state
	function automatic yags_rsp_t predict_branch(input yags_req_t r);
		logic [ADDR_W-1:0]    shifted;
		logic [CHOICE_IW-1:0] cidx;
		logic [HIST_W-1:0]    gidx;
		logic [HIST_W-1:0]    saved_h;
		logic [TAG_W-1:0]     tag;
		yags_rsp_t            res;
		shifted = r.branch_address >> shift_amt;
		cidx = shifted[CHOICE_IW-1:0];
		tag = r.branch_address[TAG_W-1:0];
		saved_h = r.saved_history[HIST_W-1:0];
		res = '0;
		res.history_snapshot = global_hist;
		case (r.cmd)
			CMD_LOOKUP: begin
				gidx = shifted[HIST_W-1:0] ^ global_hist;
				res.choice_taken = choice_ctr[cidx] > CHOICE_CW'(CHOICE_THRESH);
				// a hit in the cache opposite to the choice overrides it
				if (res.choice_taken) begin
					if (not_taken_tag[gidx] == tag) begin
						res.prediction = not_taken_ctr[gidx] > CACHE_CW'(CACHE_THRESH);
						res.cache_hit = 1'b1;
					end else begin
						res.prediction = 1'b1;
					end
				end else begin
					if (taken_tag[gidx] == tag) begin
						res.prediction = taken_ctr[gidx] > CACHE_CW'(CACHE_THRESH);
						res.cache_hit = 1'b1;
					end else begin
						res.prediction = 1'b0;
					end
				end
				global_hist = {global_hist[HIST_W-2:0], res.prediction};
			end
			CMD_UNCOND: begin
				res.prediction = 1'b1;
				res.choice_taken = 1'b1;
				global_hist = {global_hist[HIST_W-2:0], 1'b1};
			end
			CMD_UPDATE: begin
				gidx = shifted[HIST_W-1:0] ^ saved_h;
				if (r.saved_cache_hit) begin
					if (r.saved_choice_taken) begin
						not_taken_ctr[gidx] = CACHE_CW'(sat_step(32'(not_taken_ctr[gidx]),
							r.outcome_taken, CACHE_MAX));
					end else begin
						taken_ctr[gidx] = CACHE_CW'(sat_step(32'(taken_ctr[gidx]),
							r.outcome_taken, CACHE_MAX));
					end
					if (r.saved_final_prediction != r.outcome_taken ||
							r.outcome_taken == r.saved_choice_taken) begin
						choice_ctr[cidx] = CHOICE_CW'(sat_step(32'(choice_ctr[cidx]),
							r.outcome_taken, CHOICE_MAX));
					end
				end else begin
					// allocate a tag only on a misprediction the choice alone made
					if (r.saved_final_prediction != r.outcome_taken) begin
						if (r.outcome_taken) begin
							taken_tag[gidx] = tag;
						end else begin
							not_taken_tag[gidx] = tag;
						end
					end
					choice_ctr[cidx] = CHOICE_CW'(sat_step(32'(choice_ctr[cidx]),
						r.outcome_taken, CHOICE_MAX));
				end
				if (r.was_squashed) begin
					global_hist = {saved_h[HIST_W-2:0], r.outcome_taken};
				end
			end
			CMD_RESTORE: begin
				global_hist = saved_h;
			end
			CMD_BTB_MISS: begin
				global_hist[0] = 1'b0;
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function automatic yags_req_t make_req(input logic [CMD_W-1:0] cmd,
			input logic [ADDR_W-1:0] pc, input logic taken, input logic squash,
			input logic [HIST_OUT_W-1:0] hist, input logic sc, input logic sf,
			input logic sh);
		yags_req_t r;
		r.cmd = cmd;
		r.branch_address = pc;
		r.outcome_taken = taken;
		r.was_squashed = squash;
		r.saved_history = hist;
		r.saved_choice_taken = sc;
		r.saved_final_prediction = sf;
		r.saved_cache_hit = sh;
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Present one transaction, hold it until accepted, then record its predicted response
	task automatic issue_request(input yags_req_t item, output yags_rsp_t predicted);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		predicted = predict_branch(item);
		predicted_rsp_q.push_back(predicted);
	endtask

	task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
			input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write the address shift, mirror it and read it back
	task automatic set_address_shift(input logic [SHIFT_W-1:0] value);
		logic [APB_DW-1:0] rd;
		apb_access(1'b1, SHIFT_REG_ADDR, APB_DW'(value), rd);
		shift_amt = value;
		apb_access(1'b0, SHIFT_REG_ADDR, '0, rd);
		check_field("address_shift readback", 32'(value), 32'(rd[SHIFT_W-1:0]));
	endtask

	// Drop valid, hold until every response is back, then let the pipeline settle
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (predicted_rsp_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Lookup/update pairs on a small set of hot branches, with restores, unconditional branches, BTB misses and noise
	task automatic run_branch_stream(input int count);
		logic [ADDR_W-1:0]     hot_pc [16];
		int                    hot_bias [16];
		open_branch_t          ob;
		yags_req_t             r;
		yags_rsp_t             p;
		logic [63:0]           raw;
		logic [HIST_OUT_W-1:0] hist;
		int                    roll;
		int                    k;
		logic                  taken;
		logic                  is_lookup;
		open_branches.delete();
		foreach (hot_pc[i]) begin
			hot_pc[i] = $urandom;
			if ($urandom_range(0, 3) == 0) begin
				hot_pc[i][TAG_W-1:0] = '0;
			end
			hot_bias[i] = $urandom_range(0, 4) * 25;
		end
		repeat (count) begin
			roll = $urandom_range(0, 99);
			is_lookup = 1'b0;
			if (roll < 12) begin
				raw = {$urandom, $urandom};
				r = raw[$bits(yags_req_t)-1:0];
			end else if (roll < 18) begin
				hist = HIST_OUT_W'($urandom);
				if (open_branches.size() > 0 && roll < 16) begin
					k = $urandom_range(0, open_branches.size() - 1);
					hist = open_branches[k].seen.history_snapshot;
				end
				r = make_req(CMD_RESTORE, $urandom, 1'b0, 1'b0, hist, 1'b0, 1'b0, 1'b0);
			end else if (roll < 22) begin
				r = make_req(CMD_UNCOND, $urandom, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
			end else if (roll < 25) begin
				r = make_req(CMD_BTB_MISS, $urandom, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
			end else if (open_branches.size() >= 4 ||
					(open_branches.size() > 0 && roll < 60)) begin
				ob = open_branches.pop_front();
				taken = $urandom_range(0, 99) < ob.bias;
				r = make_req(CMD_UPDATE, ob.pc, taken,
					(taken != ob.seen.prediction && $urandom_range(0, 1) == 1) ||
						$urandom_range(0, 9) == 0,
					ob.seen.history_snapshot, ob.seen.choice_taken,
					ob.seen.prediction, ob.seen.cache_hit);
			end else begin
				k = $urandom_range(0, 15);
				r = make_req(CMD_LOOKUP, hot_pc[k], 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), HIST_OUT_W'($urandom),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
				is_lookup = 1'b1;
				ob.pc = hot_pc[k];
				ob.bias = hot_bias[k];
			end
			issue_request(r, p);
			if (is_lookup) begin
				ob.seen = p;
				open_branches.push_back(ob);
			end
		end
	endtask

	task automatic test_register_access();
		logic [APB_DW-1:0] rd;
		apb_access(1'b0, SHIFT_REG_ADDR, '0, rd);
		check_field("address_shift reset", 32'(SHIFT_RESET), 32'(rd[SHIFT_W-1:0]));
		set_address_shift(SHIFT_RESET);
	endtask

	task automatic test_directed_cases();
		localparam logic [ADDR_W-1:0] PC_A = 32'h0000_1234;
		localparam logic [HIST_OUT_W-1:0] H_A = 10'h155;
		yags_rsp_t p;
		// cleared tables: tag zero hits the taken cache with a zero counter
		issue_request(make_req(CMD_LOOKUP, '0, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0), p);
		issue_request(make_req(CMD_LOOKUP, '1, 1'b1, 1'b1, '1, 1'b1, 1'b1, 1'b1), p);
		issue_request(make_req(CMD_UNCOND, '1, 1'b1, 1'b1, '1, 1'b1, 1'b1, 1'b1), p);
		issue_request(make_req(CMD_BTB_MISS, '1, 1'b1, 1'b1, '1, 1'b1, 1'b1, 1'b1), p);
		issue_request(make_req(CMD_RESTORE, '0, 1'b0, 1'b0, '1, 1'b0, 1'b0, 1'b0), p);
		issue_request(make_req(CMD_BTB_MISS, '0, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0), p);
		// mispredict with no hit allocates a taken tag, the next lookup hits it
		issue_request(make_req(CMD_UPDATE, PC_A, 1'b1, 1'b0, H_A, 1'b0, 1'b0, 1'b0), p);
		issue_request(make_req(CMD_RESTORE, '0, 1'b0, 1'b0, H_A, 1'b0, 1'b0, 1'b0), p);
		issue_request(make_req(CMD_LOOKUP, PC_A, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0), p);
		issue_request(make_req(CMD_UPDATE, PC_A, 1'b1, 1'b0, H_A, 1'b0, 1'b0, 1'b1), p);
		issue_request(make_req(CMD_UPDATE, PC_A, 1'b1, 1'b0, H_A, 1'b0, 1'b0, 1'b1), p);
		// choice now taken: miss in the not-taken cache, then allocate there
		issue_request(make_req(CMD_RESTORE, '0, 1'b0, 1'b0, H_A, 1'b0, 1'b0, 1'b0), p);
		issue_request(make_req(CMD_LOOKUP, PC_A, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0), p);
		issue_request(make_req(CMD_UPDATE, PC_A, 1'b0, 1'b0, H_A, 1'b1, 1'b1, 1'b0), p);
		issue_request(make_req(CMD_RESTORE, '0, 1'b0, 1'b0, H_A, 1'b0, 1'b0, 1'b0), p);
		issue_request(make_req(CMD_LOOKUP, PC_A, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0), p);
		// correct cache-decided prediction leaves the choice counter alone
		issue_request(make_req(CMD_UPDATE, PC_A, 1'b0, 1'b0, H_A, 1'b1, 1'b0, 1'b1), p);
		// squashed updates rebuild history from the snapshot
		issue_request(make_req(CMD_UPDATE, '1, 1'b1, 1'b1, '1, 1'b1, 1'b1, 1'b1), p);
		issue_request(make_req(CMD_UPDATE, '0, 1'b0, 1'b1, '0, 1'b0, 1'b1, 1'b0), p);
		// unused commands change nothing
		issue_request(make_req(3'd5, '1, 1'b1, 1'b1, '1, 1'b1, 1'b1, 1'b1), p);
		issue_request(make_req(3'd6, '0, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0), p);
		issue_request(make_req(3'd7, '1, 1'b1, 1'b1, '1, 1'b1, 1'b1, 1'b1), p);
		issue_request(make_req(CMD_LOOKUP, '1, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0), p);
	endtask

	task automatic test_shift_settings();
		logic [SHIFT_W-1:0] settings [5] = '{3'd0, 3'd4, 3'd7, 3'd1, 3'd3};
		foreach (settings[i]) begin
			wait_drained();
			set_address_shift(settings[i]);
			run_branch_stream(120);
		end
	endtask

	task automatic test_drain_pause();
		repeat (4) begin
			run_branch_stream(10);
			wait_drained();
		end
	endtask

	task automatic test_mixed_traffic();
		run_branch_stream(950);
	endtask

	task automatic test_back_to_back();
		wait_drained();
		set_address_shift(SHIFT_RESET);
		idle_en = 1'b0;
		run_branch_stream(250);
	endtask

	// Check each response and drive the receiver stalls
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			if (predicted_rsp_q.size() == 0) begin
				$display("%0t: unexpected response, expected none, actual %0h", $time, rsp);
				mismatch_count++;
			end else begin
				expected_rsp = predicted_rsp_q.pop_front();
				check_field("prediction", 32'(expected_rsp.prediction),
					32'(rsp.prediction));
				check_field("choice_taken", 32'(expected_rsp.choice_taken),
					32'(rsp.choice_taken));
				check_field("cache_hit", 32'(expected_rsp.cache_hit),
					32'(rsp.cache_hit));
				check_field("history_snapshot", 32'(expected_rsp.history_snapshot),
					32'(rsp.history_snapshot));
			end
		end
		if (rsp_hold_left > 0) begin
			rsp_ready <= 1'b0;
			rsp_hold_left <= rsp_hold_left - 1;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			rsp_ready <= 1'b0;
			rsp_hold_left <= $urandom_range(0, 7);
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
				(psel && penable && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_yags_branch_predictor: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		for (int i = 0; i < CHOICE_N; i++) begin
			choice_ctr[i] = '0;
		end
		for (int i = 0; i < CACHE_N; i++) begin
			taken_ctr[i] = '0;
			not_taken_ctr[i] = '0;
			taken_tag[i] = '0;
			not_taken_tag[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_register_access();
		test_directed_cases();
		test_shift_settings();
		test_drain_pause();
		test_mixed_traffic();
		test_back_to_back();
		req_valid <= 1'b0;
		while (predicted_rsp_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && predicted_rsp_q.size() == 0) begin
			$display("tb_yags_branch_predictor: PASS");
		end else begin
			$display("tb_yags_branch_predictor: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
